// ===== hw/rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bump frame allocator package
// Shared widths, payload words, operation and status codes for the allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // Address width of the frame pointer and of the region table entries.
    localparam int ADDR_BITS = 48;

    // Frame size in bytes; a power of two, so alignment is a bit mask.
    localparam int FRAME_BYTES = 4096;
    localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
    localparam int HI_W        = ADDR_BITS - FRAME_SHIFT;

    // Default depth of the reserved region table.
    localparam int MAX_REGIONS_DEF = 32;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 2'd2;

    // Operation codes of an input word.
    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_RESTART = 2'd1,
        OP_ALLOC   = 2'd2
    } op_t;

    // Status codes of a result word.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_ALLOC = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        op_t         op;
        logic [4:0]  region_index;
        logic [47:0] region_start;
        logic [47:0] region_end;
    } in_word_t;

    typedef struct packed {
        status_t     status;
        logic [47:0] frame_address;
    } out_word_t;

    // One entry of the reserved region table.
    typedef struct packed {
        logic [ADDR_BITS-1:0] start_addr;
        logic [ADDR_BITS-1:0] end_addr;
    } region_t;

    // Outcome of checking the current frame against one region.
    typedef struct packed {
        logic                 hit;
        logic [ADDR_BITS-1:0] ptr;
        logic [ADDR_BITS:0]   top;
    } skip_t;

endpackage

// ===== hw/rtl/bfa_skip.sv =====
// ----------------------------------------------------------------------------
// Region skip check
// Tests whether the frame at the pointer touches, overlaps or covers one
// reserved region and gives the frame just past that region's end.
// ----------------------------------------------------------------------------
module bfa_skip (
    input  logic [bfa_pkg::ADDR_BITS-1:0] ptr,
    input  logic [bfa_pkg::ADDR_BITS:0]   top,
    input  bfa_pkg::region_t              region,
    output bfa_pkg::skip_t                skip
);
    import bfa_pkg::*;

    logic                 top_ovf;
    logic [ADDR_BITS-1:0] top_addr;
    logic                 ptr_in;
    logic                 tail_in;
    logic                 covers;
    logic [HI_W-1:0]      end_hi;
    logic [HI_W-1:0]      skip_hi;
    logic [HI_W:0]        skip_top_hi;

    // The top of the frame lies above every address when it carries out.
    assign top_ovf  = top[ADDR_BITS];
    assign top_addr = top[ADDR_BITS-1:0];

    // Hit test against the region bounds.
    assign ptr_in  = (ptr >= region.start_addr) && (ptr <= region.end_addr);
    assign tail_in = !top_ovf && (top_addr > region.start_addr)
                     && (top_addr <= region.end_addr);
    assign covers  = (ptr <= region.start_addr)
                     && (top_ovf || (top_addr >= region.end_addr));

    // Frame after the aligned-down region end, and the top of that frame.
    assign end_hi      = region.end_addr[ADDR_BITS-1:FRAME_SHIFT];
    assign skip_hi     = end_hi + HI_W'(1);
    assign skip_top_hi = {1'b0, skip_hi} + (HI_W+1)'(1);

    assign skip.hit = ptr_in || tail_in || covers;
    assign skip.ptr = {skip_hi, {FRAME_SHIFT{1'b0}}};
    assign skip.top = {skip_top_hi, {FRAME_SHIFT{1'b0}}};

endmodule

// ===== hw/rtl/bump_frame_allocator_skip_reserved.sv =====
// ----------------------------------------------------------------------------
// Bump frame allocator with reserved region skipping
// Load, restart and allocate words against a table of reserved regions.
// ----------------------------------------------------------------------------
// Load, restart and an exhausted allocate go from idle straight to the finish
// state; any other allocate first scans n entries, n being the region count
// saturated to MAX_REGIONS, as the region table memory is read and checked one
// entry per cycle. One word is in flight at a time; a finished result may wait
// in the output register while the next word is accepted. Reset sets the pointer
// to all ones and clears the control registers; the region table is undefined until loaded.
module bump_frame_allocator_skip_reserved #(
    parameter int MAX_REGIONS = bfa_pkg::MAX_REGIONS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  bfa_pkg::in_word_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output bfa_pkg::out_word_t                 out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [47:0]                        cfg_data
);
    import bfa_pkg::*;

    localparam int AW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int WIDE_W = 9;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_BITS-1:0] memory_start_reg;
    logic [ADDR_BITS-1:0] memory_end_reg;
    logic [5:0]           region_count_reg;
    logic [ADDR_BITS-1:0] frame_reg, frame_next;
    logic [ADDR_BITS:0]   top_reg, top_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic [CNT_W-1:0]     last_reg, last_next;
    status_t              status_reg, status_next;
    logic                 out_valid_reg;
    out_word_t            out_data_reg;

    region_t              table_mem [MAX_REGIONS];
    region_t              rd_data_reg;
    logic [AW-1:0]        rd_addr;

    logic                 in_fire;
    logic                 out_free;
    logic                 exhausted;
    logic [WIDE_W-1:0]    index_wide;
    logic                 index_ok;
    logic [WIDE_W-1:0]    count_wide;
    logic [WIDE_W-1:0]    count_sat;
    logic [CNT_W-1:0]     scan_inc;
    skip_t                skip;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memory_start_reg <= '0;
            memory_end_reg   <= '0;
            region_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MEMORY_START: memory_start_reg <= cfg_data[ADDR_BITS-1:0];
                CFG_MEMORY_END:   memory_end_reg   <= cfg_data[ADDR_BITS-1:0];
                CFG_REGION_COUNT: region_count_reg <= cfg_data[5:0];
                default:          ;
            endcase
        end
    end

    // Slot range check and saturated region count.
    assign index_wide = WIDE_W'(in_data.region_index);
    assign index_ok   = index_wide < WIDE_W'(MAX_REGIONS);
    assign count_wide = WIDE_W'(region_count_reg);
    assign count_sat  = (count_wide > WIDE_W'(MAX_REGIONS)) ?
                        WIDE_W'(MAX_REGIONS) : count_wide;

    // The pointer is exhausted when its frame top carries out or reaches the end.
    assign exhausted = top_reg[ADDR_BITS] || (top_reg[ADDR_BITS-1:0] >= memory_end_reg);

    // Read address: entry zero while idle, otherwise the entry after the one
    // being checked, so that one entry is checked in every cycle.
    assign scan_inc = scan_reg + CNT_W'(1);
    assign rd_addr  = (state_reg == S_IDLE) ? AW'(0) : scan_inc[AW-1:0];

    // Region table memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (in_fire && (in_data.op == OP_LOAD) && index_ok)
        begin
            table_mem[index_wide[AW-1:0]] <= '{start_addr: in_data.region_start,
                                               end_addr:   in_data.region_end};
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    bfa_skip u_skip (
        .ptr    (frame_reg),
        .top    (top_reg),
        .region (rd_data_reg),
        .skip   (skip)
    );

    // Sequencer: accept, scan the table, then hand the result to the output.
    always_comb
    begin
        state_next  = state_reg;
        frame_next  = frame_reg;
        top_next    = top_reg;
        scan_next   = scan_reg;
        last_next   = last_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    scan_next   = '0;
                    last_next   = CNT_W'(count_sat - WIDE_W'(1));
                    status_next = ST_DONE;
                    state_next  = S_FINISH;
                    case (in_data.op)
                        OP_RESTART:
                        begin
                            frame_next = memory_start_reg;
                            top_next   = {1'b0, memory_start_reg}
                                         + (ADDR_BITS+1)'(FRAME_BYTES);
                        end
                        OP_ALLOC:
                        begin
                            if (exhausted)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                status_next = ST_ALLOC;
                                if (count_sat != '0)
                                begin
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (skip.hit)
                begin
                    frame_next = skip.ptr;
                    top_next   = skip.top;
                end
                scan_next = scan_inc;
                if (scan_reg == last_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (status_reg == ST_ALLOC)
                    begin
                        frame_next = top_reg[ADDR_BITS-1:0];
                        top_next   = {1'b0, top_reg[ADDR_BITS-1:0]}
                                     + (ADDR_BITS+1)'(FRAME_BYTES);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            frame_reg  <= '1;
            top_reg    <= {1'b0, {ADDR_BITS{1'b1}}} + (ADDR_BITS+1)'(FRAME_BYTES);
            scan_reg   <= '0;
            last_reg   <= '0;
            status_reg <= ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            frame_reg  <= frame_next;
            top_reg    <= top_next;
            scan_reg   <= scan_next;
            last_reg   <= last_next;
            status_reg <= status_next;
        end
    end

    // Output register holds one result word until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_FINISH) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_FINISH) && out_free)
        begin
            out_data_reg.status        <= status_reg;
            out_data_reg.frame_address <= (status_reg == ST_ALLOC) ? frame_reg : '0;
        end
    end

endmodule

// ===== tb/bump_frame_allocator_skip_reserved_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bump frame allocator testbench
// Drives load, restart, allocate and unused-code words into the allocator under random
// idling on both sides. Every result word is checked against a predictor
// that keeps its own region table, frame pointer and register copies.
// ----------------------------------------------------------------------------
module bump_frame_allocator_skip_reserved_test;
    import bfa_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;
    localparam logic [1:0]           OP_UNUSED_CODE = 2'd3;
    localparam bit [ADDR_BITS-1:0]   FRAME_STEP     = ADDR_BITS'(FRAME_BYTES);
    localparam bit [ADDR_BITS-1:0]   ALIGN_MASK     = ~(FRAME_STEP - 1);

    // Predicts every result word from the words the allocator has taken.
    class frame_ledger;
        bit [ADDR_BITS-1:0] slot_start [MAX_REGIONS_DEF];
        bit [ADDR_BITS-1:0] slot_end [MAX_REGIONS_DEF];
        bit [ADDR_BITS-1:0] pointer;
        bit [ADDR_BITS-1:0] mem_lo;
        bit [ADDR_BITS-1:0] mem_hi;
        bit [5:0]           count;
        out_word_t          owed_replies[$];
        int                 faults;

        function new();
            pointer = '1;
            mem_lo  = '0;
            mem_hi  = '0;
            count   = '0;
            faults  = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [47:0] value);
            case (idx)
                CFG_MEMORY_START: mem_lo = value;
                CFG_MEMORY_END:   mem_hi = value;
                CFG_REGION_COUNT: count = value[5:0];
                default: ;
            endcase
        endfunction

        // A frame touches, overlaps or covers a region. A frame whose top
        // carries out of the address lies above every address.
        function bit frame_hits(bit [ADDR_BITS-1:0] p, bit [ADDR_BITS-1:0] s,
                                bit [ADDR_BITS-1:0] e);
            bit [ADDR_BITS:0]   top;
            bit [ADDR_BITS-1:0] t;
            bit                 carry;
            top   = {1'b0, p} + {1'b0, FRAME_STEP};
            carry = top[ADDR_BITS];
            t     = top[ADDR_BITS-1:0];
            return (p >= s && p <= e) || (!carry && t > s && t <= e) ||
                   (p <= s && (carry || t >= e));
        endfunction

        function void accept_request(in_word_t w);
            out_word_t          reply;
            bit [ADDR_BITS:0]   top;
            bit [ADDR_BITS-1:0] p;
            int                 n;
            reply.status        = ST_DONE;
            reply.frame_address = '0;
            case (w.op)
                OP_LOAD:
                begin
                    slot_start[w.region_index] = w.region_start;
                    slot_end[w.region_index]   = w.region_end;
                end
                OP_RESTART: pointer = mem_lo;
                OP_ALLOC:
                begin
                    top = {1'b0, pointer} + {1'b0, FRAME_STEP};
                    if (top[ADDR_BITS] || top[ADDR_BITS-1:0] >= mem_hi)
                    begin
                        reply.status = ST_EMPTY;
                    end
                    else
                    begin
                        // One pass over the table in order; each hit moves
                        // the frame past that region's aligned-down end.
                        n = (count > MAX_REGIONS_DEF) ? MAX_REGIONS_DEF : count;
                        p = pointer;
                        for (int i = 0; i < n; i++)
                        begin
                            if (frame_hits(p, slot_start[i], slot_end[i]))
                                p = (slot_end[i] & ALIGN_MASK) + FRAME_STEP;
                        end
                        reply.status        = ST_ALLOC;
                        reply.frame_address = p;
                        pointer             = p + FRAME_STEP;
                    end
                end
                default: ;
            endcase
            owed_replies.push_back(reply);
        endfunction

        task report(string what);
            if (faults < 50)
                $display("error at %0t ns: %s", $time, what);
            faults++;
        endtask

        task check_reply(out_word_t got);
            out_word_t want;
            if (owed_replies.size() == 0)
            begin
                report($sformatf("result word %h with nothing outstanding", got));
                return;
            end
            want = owed_replies.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, predicted %0d", got.status, want.status));
            if (got.frame_address !== want.frame_address)
                report($sformatf("frame_address %h, predicted %h",
                                 got.frame_address, want.frame_address));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    in_word_t           in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    out_word_t          out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [47:0]        cfg_data = '0;

    frame_ledger        ledger = new;
    int                 send_idle_pct = 12;
    int                 recv_idle_pct = 71;
    bit                 slot_loaded [MAX_REGIONS_DEF];
    bit [ADDR_BITS-1:0] window_base = '0;
    int                 window_frames = 16;

    bump_frame_allocator_skip_reserved dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Receiver side: stall at random, then check each word taken.
    always @(posedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            ledger.check_reply(out_data);
    end

    function automatic bit [47:0] rand48();
        bit [63:0] v;
        v = {$urandom, $urandom};
        return v[47:0];
    endfunction

    function automatic in_word_t make_word(op_t op, bit [4:0] slot, bit [47:0] s,
                                           bit [47:0] e);
        in_word_t w;
        w.op           = op;
        w.region_index = slot;
        w.region_start = s;
        w.region_end   = e;
        return w;
    endfunction

    // Regions mostly fall inside the current memory window so that frames
    // collide with them; a few are wild, inverted or frame aligned.
    function automatic in_word_t random_region(bit [4:0] slot);
        bit [47:0] s;
        bit [47:0] e;
        int        k;
        k = $urandom_range(0, 19);
        s = window_base + (48'($urandom_range(0, window_frames)) << FRAME_SHIFT)
            + 48'($urandom_range(0, FRAME_BYTES - 1));
        e = s + 48'($urandom_range(0, 3 * FRAME_BYTES));
        if (k < 2)
        begin
            s = rand48();
            e = rand48();
        end
        else if (k == 2)
            e = s - 48'($urandom_range(1, FRAME_BYTES));
        else if (k == 3)
            s = s & ALIGN_MASK;
        return make_word(OP_LOAD, slot, s, e);
    endfunction

    // Offers one input word after a random gap and waits for it to be taken.
    task automatic send_word(input in_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        ledger.accept_request(w);
        if (w.op == OP_LOAD)
            slot_loaded[w.region_index] = 1'b1;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        ledger.write_register(idx, value);
    endtask

    // Registers change only once every outstanding result has come back.
    task automatic configure(input bit [47:0] lo, input bit [47:0] hi,
                             input bit [47:0] cnt);
        in_valid <= 1'b0;
        while (ledger.owed_replies.size() != 0) @(posedge clk);
        write_reg(CFG_UNUSED, rand48());
        write_reg(CFG_MEMORY_START, lo);
        write_reg(CFG_MEMORY_END, hi);
        write_reg(CFG_REGION_COUNT, cnt);
        cfg_valid <= 1'b0;
        window_base = lo & ALIGN_MASK;
        if (hi > lo)
            window_frames = ((hi - lo) >> FRAME_SHIFT) > 200 ? 200 :
                            int'((hi - lo) >> FRAME_SHIFT);
        else
            window_frames = 16;
    endtask

    // Every slot that an allocation will scan must be loaded first.
    task automatic fill_slots(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (!slot_loaded[i])
                send_word(random_region(5'(i)));
        end
    endtask

    // Stimulus: a directed opening, then random phases over several settings.
    initial
    begin
        bit [47:0] lo;
        bit [47:0] hi;
        bit [47:0] cnt;
        int        pick;
        int        items;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight after reset the pointer is all ones, so allocation fails.
        send_word(make_word(OP_ALLOC, 5'd0, 48'd0, 48'd0));
        send_word(make_word(op_t'(OP_UNUSED_CODE), 5'd31, '1, '1));
        send_word(make_word(OP_RESTART, 5'd0, 48'd0, 48'd0));
        // Memory end still zero: exhausted at once.
        send_word(make_word(OP_ALLOC, 5'd0, 48'd0, 48'd0));

        // Touching, inside and covering regions next to an unaligned start.
        configure(48'h0000_0000_1800, 48'h0000_0004_0000, 48'd4);
        send_word(make_word(OP_LOAD, 5'd0, 48'h0000_0000_2800, 48'h0000_0000_2800));
        send_word(make_word(OP_LOAD, 5'd1, 48'h0000_0000_3000, 48'h0000_0000_4fff));
        send_word(make_word(OP_LOAD, 5'd2, 48'h0000_0000_7000, 48'h0000_0000_7000));
        send_word(make_word(OP_LOAD, 5'd3, 48'h0000_0000_5800, 48'h0000_0000_5900));
        send_word(make_word(OP_LOAD, 5'd31, 48'd0, '1));
        send_word(make_word(OP_LOAD, 5'd30, '1, 48'd0));
        send_word(make_word(OP_RESTART, 5'd0, 48'd0, 48'd0));
        repeat (6) send_word(make_word(OP_ALLOC, 5'd0, 48'd0, 48'd0));

        // Top of the address space: frame past the top and pointer wrap.
        configure(48'hffff_ffff_d000, 48'hffff_ffff_ffff, 48'd2);
        send_word(make_word(OP_LOAD, 5'd0, 48'hffff_ffff_d800, 48'hffff_ffff_e010));
        send_word(make_word(OP_LOAD, 5'd1, 48'hffff_ffff_f800, 48'hffff_ffff_ffff));
        send_word(make_word(OP_RESTART, 5'd0, 48'd0, 48'd0));
        repeat (4) send_word(make_word(OP_ALLOC, 5'd0, 48'd0, 48'd0));

        for (int k = 0; k < 9; k++)
        begin
            // Idling: sender light and receiver heavy, then swapped, then none.
            if (k < 3)
            begin
                send_idle_pct = 12;
                recv_idle_pct = 71;
            end
            else if (k < 6)
            begin
                send_idle_pct = 71;
                recv_idle_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (k)
                0:
                begin
                    lo  = '0;
                    hi  = '1;
                    cnt = 48'd32;
                end
                1:
                begin
                    lo  = rand48() & ALIGN_MASK;
                    hi  = lo + 64 * FRAME_STEP;
                    cnt = 48'd63;
                end
                2:
                begin
                    lo  = 48'hffff_fffd_8000;
                    hi  = '1;
                    cnt = 48'd8;
                end
                3:
                begin
                    lo  = rand48();
                    hi  = lo + 30 * FRAME_STEP;
                    cnt = 48'd0;
                end
                4:
                begin
                    lo  = '1;
                    hi  = '0;
                    cnt = rand48();
                    cnt[5:0] = 6'd5;
                end
                default:
                begin
                    lo = rand48();
                    if ($urandom_range(0, 1) == 0)
                        lo = lo & ALIGN_MASK;
                    hi  = lo + 48'($urandom_range(2, 120)) * FRAME_STEP
                          + 48'($urandom_range(0, FRAME_BYTES - 1));
                    cnt = 48'($urandom_range(0, 40));
                end
            endcase
            configure(lo, hi, cnt);
            fill_slots(cnt[5:0] > MAX_REGIONS_DEF ? MAX_REGIONS_DEF : cnt[5:0]);

            // Mostly allocations, with restarts to rewind and fresh regions.
            items = (k == 4) ? 60 : 160;
            for (int j = 0; j < items; j++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    send_word(random_region(5'($urandom_range(0, 31))));
                else if (pick < 18)
                    send_word(make_word(OP_RESTART, 5'($urandom), rand48(), rand48()));
                else if (pick < 20)
                    send_word(make_word(op_t'(OP_UNUSED_CODE), 5'($urandom),
                                        rand48(), rand48()));
                else
                    send_word(make_word(OP_ALLOC, 5'($urandom), rand48(), rand48()));
            end
        end

        in_valid <= 1'b0;
        while (ledger.owed_replies.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (ledger.faults == 0)
            $display("bump_frame_allocator_skip_reserved: match");
        else
            $display("bump_frame_allocator_skip_reserved: mismatch");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("bump_frame_allocator_skip_reserved: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_skip.sv
hw/rtl/bump_frame_allocator_skip_reserved.sv
tb/bump_frame_allocator_skip_reserved_test.sv
